@@ hdl/hba_pkg.sv @@
package hba_pkg;

  localparam int NUM_BINS_DEF = 256;

  localparam int DATA_W  = 32;
  localparam int PROD_W  = 64;
  localparam int LIMIT_W = 9;
  localparam int BIN_W   = 8;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] REG_RANGE_START = 2'd0;
  localparam logic [1:0] REG_BIN_SCALE   = 2'd1;
  localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

  localparam logic [DATA_W-1:0]  RANGE_START_RST = 32'd0;
  localparam logic [DATA_W-1:0]  BIN_SCALE_RST   = 32'd65536;
  localparam logic [LIMIT_W-1:0] BINS_IN_USE_RST = 9'd256;

  typedef struct packed {
    logic clr_we;
    logic accept;
    logic mul_en;
    logic bin_en;
    logic upd_en;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } ctl_sts_t;

endpackage

@@ hdl/histogram_bin_add_remove.sv @@
// channel   signals                                   direction
// in        in_valid/in_ready: mode, sample, read_bin  request in
// out       out_valid/out_ready: bin_index, in_range,  request out
//           bin_count
// cfg       cfg_we, cfg_index, cfg_data                write only
//
// One request passes in order through accept/subtract, multiply, bin check,
// RAM read and update/write-back; its result is registered in the update step.
// A new request is taken once the previous one has written back.
// After reset the count RAM is cleared bin by bin, with in_ready low.
// The result register holds while out_ready is low; a request may be
// accepted meanwhile and waits in its update step until the register frees.
module histogram_bin_add_remove #(
  parameter int NUM_BINS = hba_pkg::NUM_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [hba_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic signed [hba_pkg::DATA_W-1:0] sample,
  input  logic [hba_pkg::BIN_W-1:0]         read_bin,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hba_pkg::BIN_W-1:0]         bin_index,
  output logic                              in_range,
  output logic signed [hba_pkg::DATA_W-1:0] bin_count
);

  hba_pkg::ctl_cmd_t cmd;
  hba_pkg::ctl_sts_t sts;

  hba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  hba_dp #(
    .NUM_BINS(NUM_BINS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .mode     (mode),
    .sample   (sample),
    .read_bin (read_bin),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .bin_index(bin_index),
    .in_range (in_range),
    .bin_count(bin_count)
  );

endmodule

@@ hdl/hba_ram.sv @@
module hba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/hba_ctrl.sv @@
module hba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hba_pkg::ctl_sts_t sts,
  output hba_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_BIN   = 3'd3;
  localparam logic [2:0] ST_FETCH = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_BIN;
      end
      ST_BIN: begin
        cmd.bin_en = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (!sts.out_busy) begin
          cmd.upd_en = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/hba_dp.sv @@
module hba_dp #(
  parameter int NUM_BINS = hba_pkg::NUM_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hba_pkg::ctl_cmd_t           cmd,
  output hba_pkg::ctl_sts_t           sts,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [hba_pkg::DATA_W-1:0]  cfg_data,
  input  logic [1:0]                  mode,
  input  logic signed [hba_pkg::DATA_W-1:0] sample,
  input  logic [hba_pkg::BIN_W-1:0]   read_bin,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hba_pkg::BIN_W-1:0]   bin_index,
  output logic                        in_range,
  output logic signed [hba_pkg::DATA_W-1:0] bin_count
);

  localparam int ABITS = $clog2(NUM_BINS);
  localparam int DW    = hba_pkg::DATA_W;
  localparam logic [DW-1:0] NB32 = DW'(NUM_BINS);
  localparam logic [ABITS-1:0] LAST_ADDR = ABITS'(NUM_BINS - 1);

  logic [DW-1:0]                    range_start;
  logic [DW-1:0]                    bin_scale;
  logic [hba_pkg::LIMIT_W-1:0]      bins_in_use;

  logic [1:0]                       mode_r;
  logic [DW:0]                      diff;
  logic [hba_pkg::BIN_W-1:0]        read_bin_r;
  logic [hba_pkg::PROD_W-1:0]       prod;
  logic                             ok;
  logic [hba_pkg::BIN_W-1:0]        bin8;
  logic [ABITS-1:0]                 addr;
  logic [ABITS-1:0]                 clr_addr;

  logic [DW-1:0]                    lim32;
  logic [DW-1:0]                    bins32;
  logic [DW-1:0]                    bin32;
  logic                             bin_ok;
  logic                             is_upd;
  logic [DW-1:0]                    rdata;
  logic [DW-1:0]                    cnt_new;
  logic                             ram_we;
  logic [ABITS-1:0]                 ram_waddr;
  logic [DW-1:0]                    ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= hba_pkg::RANGE_START_RST;
      bin_scale   <= hba_pkg::BIN_SCALE_RST;
      bins_in_use <= hba_pkg::BINS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hba_pkg::REG_RANGE_START: range_start <= cfg_data;
        hba_pkg::REG_BIN_SCALE:   bin_scale   <= cfg_data;
        hba_pkg::REG_BINS_IN_USE: bins_in_use <= cfg_data[hba_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign bins32 = DW'(bins_in_use);
  assign lim32  = (bins32 < NB32) ? bins32 : NB32;
  assign is_upd = (mode_r == hba_pkg::MODE_ADD) || (mode_r == hba_pkg::MODE_REMOVE);

  // negative difference lands in bin 0 only with a zero scale
  always_comb begin
    bin32  = '0;
    bin_ok = 1'b0;
    case (mode_r)
      hba_pkg::MODE_ADD, hba_pkg::MODE_REMOVE: begin
        if (diff[DW]) begin
          bin_ok = (bin_scale == '0);
        end else begin
          bin32  = prod[hba_pkg::PROD_W-1:DW];
          bin_ok = 1'b1;
        end
      end
      hba_pkg::MODE_READ: begin
        bin32  = DW'(read_bin_r);
        bin_ok = 1'b1;
      end
      default: ;
    endcase
    bin_ok = bin_ok && (bin32 < lim32);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r     <= mode;
      diff       <= {sample[DW-1], sample} - {range_start[DW-1], range_start};
      read_bin_r <= read_bin;
    end
    if (cmd.mul_en) begin
      prod <= diff[DW-1:0] * bin_scale;
    end
    if (cmd.bin_en) begin
      ok   <= bin_ok;
      bin8 <= bin_ok ? bin32[hba_pkg::BIN_W-1:0] : '0;
      addr <= bin32[ABITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_we) begin
      clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + 1'b1;
    end
  end

  always_comb begin
    case (mode_r)
      hba_pkg::MODE_ADD:    cnt_new = rdata + 1'b1;
      hba_pkg::MODE_REMOVE: cnt_new = rdata - 1'b1;
      default:              cnt_new = rdata;
    endcase
  end

  assign ram_we    = cmd.clr_we || (cmd.upd_en && ok && is_upd);
  assign ram_waddr = cmd.clr_we ? clr_addr : addr;
  assign ram_wdata = cmd.clr_we ? '0 : cnt_new;

  hba_ram #(
    .WIDTH(DW),
    .DEPTH(NUM_BINS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      bin_index <= bin8;
      in_range  <= ok;
      bin_count <= ok ? cnt_new : '0;
    end
  end

  assign sts.clr_last = (clr_addr == LAST_ADDR);
  assign sts.out_busy = out_valid && !out_ready;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;
  localparam int REQS_PER_PHASE = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [hba_pkg::BIN_W-1:0]         bin_index;
    logic                              in_range;
    logic signed [hba_pkg::DATA_W-1:0] bin_count;
  } hist_result_t;

  typedef struct packed {
    logic [1:0]                 m;
    logic [hba_pkg::DATA_W-1:0] s;
    logic [hba_pkg::BIN_W-1:0]  rb;
    logic                       typed;
    hist_result_t               res;
  } hist_row_t;

  // Reset settings: bins of width 1.0 starting at 0, all 256 counted
  localparam int NROWS = 21;
  localparam hist_row_t DIRECTED_ROWS [NROWS] = '{
    '{hba_pkg::MODE_READ,   32'h0000_0000, 8'd0,   1'b1, '{8'd0,   1'b1, 32'd0}},
    '{hba_pkg::MODE_READ,   32'h0000_0000, 8'd255, 1'b1, '{8'd255, 1'b1, 32'd0}},
    '{hba_pkg::MODE_ADD,    32'h0000_0000, 8'd0,   1'b1, '{8'd0,   1'b1, 32'd1}},
    '{hba_pkg::MODE_ADD,    32'h0000_FFFF, 8'd0,   1'b1, '{8'd0,   1'b1, 32'd2}},
    '{hba_pkg::MODE_REMOVE, 32'h0000_0000, 8'd0,   1'b1, '{8'd0,   1'b1, 32'd1}},
    '{hba_pkg::MODE_ADD,    32'h00FF_FFFF, 8'd0,   1'b1, '{8'd255, 1'b1, 32'd1}},
    '{hba_pkg::MODE_ADD,    32'h0100_0000, 8'd0,   1'b1, '{8'd0,   1'b0, 32'd0}},
    '{hba_pkg::MODE_ADD,    32'h8000_0000, 8'd0,   1'b1, '{8'd0,   1'b0, 32'd0}},
    '{hba_pkg::MODE_ADD,    32'h7FFF_FFFF, 8'd0,   1'b1, '{8'd0,   1'b0, 32'd0}},
    '{hba_pkg::MODE_ADD,    32'hFFFF_FFFF, 8'd0,   1'b1, '{8'd0,   1'b0, 32'd0}},
    '{hba_pkg::MODE_REMOVE, 32'h0005_0000, 8'd0,   1'b1, '{8'd5,   1'b1, 32'hFFFF_FFFF}},
    '{hba_pkg::MODE_REMOVE, 32'h0005_FFFF, 8'd0,   1'b1, '{8'd5,   1'b1, 32'hFFFF_FFFE}},
    '{hba_pkg::MODE_ADD,    32'h0005_8000, 8'd0,   1'b1, '{8'd5,   1'b1, 32'hFFFF_FFFF}},
    '{hba_pkg::MODE_READ,   32'h7FFF_FFFF, 8'd5,   1'b1, '{8'd5,   1'b1, 32'hFFFF_FFFF}},
    '{MODE_NONE,            32'h0000_0000, 8'd0,   1'b1, '{8'd0,   1'b0, 32'd0}},
    '{MODE_NONE,            32'hFFFF_FFFF, 8'd255, 1'b1, '{8'd0,   1'b0, 32'd0}},
    '{hba_pkg::MODE_REMOVE, 32'h8000_0000, 8'd0,   1'b1, '{8'd0,   1'b0, 32'd0}},
    '{hba_pkg::MODE_ADD,    32'h0080_7FFF, 8'h80,  1'b0, '{8'd0,   1'b0, 32'd0}},
    '{hba_pkg::MODE_READ,   32'h0000_0000, 8'h80,  1'b0, '{8'd0,   1'b0, 32'd0}},
    '{hba_pkg::MODE_READ,   32'hFFFF_FFFF, 8'd0,   1'b1, '{8'd0,   1'b1, 32'd1}},
    '{hba_pkg::MODE_READ,   32'h0000_0000, 8'd255, 1'b1, '{8'd255, 1'b1, 32'd1}}
  };

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [1:0]                        cfg_index = '0;
  logic [hba_pkg::DATA_W-1:0]        cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [1:0]                        mode = '0;
  logic signed [hba_pkg::DATA_W-1:0] sample = '0;
  logic [hba_pkg::BIN_W-1:0]         read_bin = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [hba_pkg::BIN_W-1:0]         bin_index;
  logic                              in_range;
  logic signed [hba_pkg::DATA_W-1:0] bin_count;

  histogram_bin_add_remove dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .sample    (sample),
    .read_bin  (read_bin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin_index (bin_index),
    .in_range  (in_range),
    .bin_count (bin_count)
  );

  always #5 clk = ~clk;

  // shadow of the block's registers and count store
  logic [hba_pkg::DATA_W-1:0]  range_start = hba_pkg::RANGE_START_RST;
  logic [hba_pkg::DATA_W-1:0]  bin_scale = hba_pkg::BIN_SCALE_RST;
  logic [hba_pkg::LIMIT_W-1:0] bins_in_use = hba_pkg::BINS_IN_USE_RST;
  logic [hba_pkg::DATA_W-1:0]  bin_counts [hba_pkg::NUM_BINS_DEF];

  hist_result_t expected_results [$];
  int  mismatches = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  bit  hold_off = 1'b0;

  initial begin
    for (int i = 0; i < hba_pkg::NUM_BINS_DEF; i++) bin_counts[i] = '0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int counted_bins();
    return (bins_in_use > hba_pkg::NUM_BINS_DEF) ? hba_pkg::NUM_BINS_DEF
                                                 : int'(bins_in_use);
  endfunction

  function automatic hist_result_t update_histogram(
      input logic [1:0] m,
      input logic [hba_pkg::DATA_W-1:0] s,
      input logic [hba_pkg::BIN_W-1:0] rb);
    logic signed [hba_pkg::DATA_W:0] diff;
    logic [hba_pkg::PROD_W-1:0]      prod;
    logic [hba_pkg::PROD_W-1:0]      bin;
    logic                            hit;
    int                              lim;
    hist_result_t                    r;
    lim = counted_bins();
    r = '0;
    hit = 1'b0;
    bin = '0;
    if (m == hba_pkg::MODE_ADD || m == hba_pkg::MODE_REMOVE) begin
      diff = $signed({s[hba_pkg::DATA_W-1], s})
           - $signed({range_start[hba_pkg::DATA_W-1], range_start});
      if (diff < 0) begin
        hit = (bin_scale == 0);
      end else begin
        prod = {31'd0, diff} * {32'd0, bin_scale};
        bin = {32'd0, prod[hba_pkg::PROD_W-1:32]};
        hit = 1'b1;
      end
      if (hit && bin < lim) begin
        if (m == hba_pkg::MODE_ADD) bin_counts[bin[7:0]] = bin_counts[bin[7:0]] + 1;
        else bin_counts[bin[7:0]] = bin_counts[bin[7:0]] - 1;
        r = '{bin[7:0], 1'b1, bin_counts[bin[7:0]]};
      end
    end else if (m == hba_pkg::MODE_READ) begin
      if (rb < lim) r = '{rb, 1'b1, bin_counts[rb]};
    end
    return r;
  endfunction

  // mostly samples aimed at the counted bins and just past them
  function automatic logic [hba_pkg::DATA_W-1:0] pick_sample();
    logic [hba_pkg::PROD_W-1:0] span;
    logic [hba_pkg::PROD_W-1:0] offs;
    int                         pick;
    pick = $urandom_range(0, 99);
    if (pick < 15 || bin_scale == 0) return $urandom;
    if (pick < 25) return range_start - $urandom_range(1, 1000);
    span = ((64'(counted_bins()) + 2) << 32) / bin_scale;
    if (span == 0) span = 1;
    offs = {$urandom, $urandom} % span;
    return range_start + offs[hba_pkg::DATA_W-1:0];
  endfunction

  task automatic send_req(input logic [1:0] m, input logic [hba_pkg::DATA_W-1:0] s,
                          input logic [hba_pkg::BIN_W-1:0] rb, input logic typed,
                          input hist_result_t typed_res);
    int           gap;
    hist_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    sample <= s;
    read_bin <= rb;
    do @(posedge clk); while (!in_ready);
    r = update_histogram(m, s, rb);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic send_random_req();
    int                        pick;
    logic [1:0]                m;
    int                        lim;
    logic [hba_pkg::BIN_W-1:0] rb;
    pick = $urandom_range(0, 99);
    lim = counted_bins();
    if (pick < 45) m = hba_pkg::MODE_ADD;
    else if (pick < 65) m = hba_pkg::MODE_REMOVE;
    else if (pick < 92) m = hba_pkg::MODE_READ;
    else m = MODE_NONE;
    if (lim > 0 && $urandom_range(0, 9) < 7) rb = hba_pkg::BIN_W'($urandom_range(0, lim - 1));
    else rb = hba_pkg::BIN_W'($urandom);
    send_req(m, pick_sample(), rb, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [hba_pkg::DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      hba_pkg::REG_RANGE_START: range_start = d;
      hba_pkg::REG_BIN_SCALE:   bin_scale = d;
      hba_pkg::REG_BINS_IN_USE: bins_in_use = d[hba_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [hba_pkg::DATA_W-1:0]  rs;
    logic [hba_pkg::DATA_W-1:0]  sc;
    logic [hba_pkg::LIMIT_W-1:0] biu;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NROWS; i++)
      send_req(DIRECTED_ROWS[i].m, DIRECTED_ROWS[i].s, DIRECTED_ROWS[i].rb,
               DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin rs = 32'h8000_0000; sc = 32'hFFFF_FFFF; biu = 9'd511; end
        1: begin rs = 32'h7FFF_FFFF; sc = 32'd0; biu = 9'd1; end
        2: begin rs = $urandom; sc = 32'd0; biu = 9'd256; end
        3: begin rs = $urandom; sc = $urandom; biu = 9'd0; end
        4: begin rs = 32'hFFF6_0000; sc = 32'h0004_0000; biu = 9'd64; end
        5: begin rs = 32'd0; sc = 32'h0001_0000; biu = 9'd256; end
        default: begin
          rs = ($urandom_range(0, 3) == 0) ? $urandom
                                           : 32'($signed($urandom_range(0, 64)) - 32) << 16;
          sc = ($urandom_range(0, 3) == 0) ? $urandom : 32'd1 << $urandom_range(12, 22);
          biu = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 256));
        end
      endcase
      write_reg(hba_pkg::REG_RANGE_START, rs);
      write_reg(hba_pkg::REG_BIN_SCALE, sc);
      write_reg(hba_pkg::REG_BINS_IN_USE, {23'd0, biu});
      cfg_we <= 1'b0;
      no_idle = (p == 4 || p == 8);
      hold_off = (p == 4);
      repeat (REQS_PER_PHASE) send_random_req();
      drain();
      no_idle = 1'b0;
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back up the pipeline
  initial begin
    int           gap;
    hist_result_t want;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result bin_index %0d in_range %0b bin_count %0d",
                 $time, bin_index, in_range, bin_count);
      end else begin
        want = expected_results.pop_front();
        if (bin_index !== want.bin_index) begin
          mismatches++;
          $display("%0t: bin_index expected %0d got %0d", $time, want.bin_index, bin_index);
        end
        if (in_range !== want.in_range) begin
          mismatches++;
          $display("%0t: in_range expected %0b got %0b", $time, want.in_range, in_range);
        end
        if (bin_count !== want.bin_count) begin
          mismatches++;
          $display("%0t: bin_count expected %0d got %0d", $time, want.bin_count, bin_count);
        end
      end
    end
  end

endmodule
